### rtl/core/bpu_pkg.sv
// bpu_pkg: shared types, constants and codes for the bmp pixel unpacker
// no dependencies; imported by the interfaces and every module of the block
`default_nettype none

package bpu_pkg;

	// widest row the block decodes, and the fixed limit on both dimensions
	localparam int MAX_WIDTH         = 4096;
	localparam int DIM_LIMIT         = 4096;
	localparam int W_LIMIT           = (MAX_WIDTH < DIM_LIMIT) ? MAX_WIDTH : DIM_LIMIT;
	localparam int PALETTE_DEPTH_DEF = 256;

	// field widths
	localparam int ACT_W      = 2;
	localparam int BYTE_W     = 8;
	localparam int COORD_W    = 12;
	localparam int DIM_W      = 13;
	localparam int BPP_W      = 6;
	localparam int BIR_W      = 15;
	localparam int CNT_W      = 4;
	localparam int PIX_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam int JOBQ_DEPTH = 4;

	// input actions
	localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
	localparam logic [ACT_W-1:0] ACT_PALETTE = 2'd1;
	localparam logic [ACT_W-1:0] ACT_DATA    = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BPP    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

	// supported pixel depths
	localparam logic [BPP_W-1:0] BPP_1  = 6'd1;
	localparam logic [BPP_W-1:0] BPP_4  = 6'd4;
	localparam logic [BPP_W-1:0] BPP_8  = 6'd8;
	localparam logic [BPP_W-1:0] BPP_16 = 6'd16;
	localparam logic [BPP_W-1:0] BPP_24 = 6'd24;
	localparam logic [BPP_W-1:0] BPP_32 = 6'd32;

	localparam logic [BPP_W-1:0] BPP_RESET    = BPP_24;
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd1;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd1;

	// job kinds travelling from the front to the back
	typedef enum logic [1:0] {
		JOB_PWR,
		JOB_PAL,
		JOB_RGB,
		JOB_ERR
	} job_kind_t;

	// palette index packing within a data byte
	typedef enum logic [1:0] {
		PD_1,
		PD_4,
		PD_8
	} pal_depth_t;

	typedef struct packed {
		job_kind_t           kind;
		pal_depth_t          depth;
		logic [BYTE_W-1:0]   data;
		logic [BYTE_W-1:0]   red;
		logic [BYTE_W-1:0]   green;
		logic [BYTE_W-1:0]   blue;
		logic [COORD_W-1:0]  col;
		logic [COORD_W-1:0]  y;
		logic [CNT_W-1:0]    count;
	} job_t;

	// row remainder unit request and response
	typedef struct packed {
		logic               start;
		logic [DIM_W-1:0]   divisor;
		logic [COORD_W-1:0] dividend;
	} rm_req_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [COORD_W-1:0] rem;
	} rm_rsp_t;

endpackage

`default_nettype wire

### rtl/core/bpu_intf.sv
// bpu_intf: valid/ready channel interfaces for input items, pixels and configuration
// depends on bpu_pkg for field widths
`default_nettype none

interface bpu_in_if import bpu_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ACT_W-1:0]  action;
	logic [BYTE_W-1:0] palette_index;
	logic [BYTE_W-1:0] palette_blue;
	logic [BYTE_W-1:0] palette_green;
	logic [BYTE_W-1:0] palette_red;
	logic [BYTE_W-1:0] data_byte;

	modport source (
		output valid, action, palette_index, palette_blue, palette_green, palette_red,
			data_byte,
		input  ready
	);
	modport sink (
		input  valid, action, palette_index, palette_blue, palette_green, palette_red,
			data_byte,
		output ready
	);
endinterface

interface bpu_out_if import bpu_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] pixel_x;
	logic [COORD_W-1:0] pixel_y;
	logic [BYTE_W-1:0]  red;
	logic [BYTE_W-1:0]  green;
	logic [BYTE_W-1:0]  blue;
	logic               status;
	logic               last;

	modport source (
		output valid, pixel_x, pixel_y, red, green, blue, status, last,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, red, green, blue, status, last,
		output ready
	);
endinterface

interface bpu_cfg_if import bpu_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/bmp_pixel_unpacker_unit.sv
// bmp_pixel_unpacker_unit: top level of the bmp pixel array unpacker
// depends on bpu_pkg, bpu_intf, bpu_rowmod, bpu_front, bpu_jobq, bpu_back
`default_nettype none

// The unit decodes a BMP pixel array fed one byte per transaction in file order and
// emits one RGB pixel per output transaction, with x and a top-down y. Depths 1, 4 and
// 8 go through the palette (load it first with palette transactions), 16 is 5-5-5
// little-endian passed through unscaled, 24 and 32 are B, G, R with the fourth byte of
// 32 skipped; row padding is skipped and any other depth answers each data byte with
// one status result. The front accepts one input transaction per cycle while the job
// queue has room and no row remainder is being recomputed; the back drains one pixel
// per cycle while the output is ready, so a 1-bit byte yields eight pixels and a
// 4-bit byte two, and the four-entry job queue absorbs that burst. Writing the height
// register holds off input while the serial remainder unit recomputes the row
// position; other register writes take effect at once.

module bmp_pixel_unpacker_unit import bpu_pkg::*; #(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	bpu_in_if.sink    item,
	bpu_cfg_if.sink   cfg,
	bpu_out_if.source pixel
);

	// front to queue
	job_t    push_job;
	logic    push;
	logic    q_full;

	// queue to back
	job_t    head_job;
	logic    head_valid;
	logic    pop;

	// row remainder unit
	rm_req_t rm_req;
	rm_rsp_t rm_rsp;

	// classification, counters and configuration
	bpu_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.q_full (q_full),
		.push   (push),
		.job    (push_job),
		.rm_req (rm_req),
		.rm_rsp (rm_rsp)
	);

	// row mod height after a height change
	bpu_rowmod u_rowmod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (rm_req),
		.rsp    (rm_rsp)
	);

	// decouples byte intake from pixel drain
	bpu_jobq #(
		.DEPTH (JOBQ_DEPTH)
	) u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_job),
		.pop    (pop),
		.dout   (head_job),
		.valid  (head_valid),
		.full   (q_full)
	);

	// palette lookup and pixel output
	bpu_back #(
		.PALETTE_DEPTH (PALETTE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job       (head_job),
		.job_valid (head_valid),
		.pop       (pop),
		.pixel     (pixel)
	);

endmodule

`default_nettype wire

### rtl/core/bpu_rowmod.sv
// bpu_rowmod: bit-serial remainder of the row counter by the image height
// depends on bpu_pkg (rm_req_t, rm_rsp_t)
`default_nettype none

module bpu_rowmod import bpu_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  rm_req_t   req,
	output rm_rsp_t   rsp
);

	localparam int STEP_W = $clog2(COORD_W);

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   step_q;
	logic [COORD_W-1:0]  dvd_q;
	logic [DIM_W-1:0]    dvs_q;
	logic [COORD_W-1:0]  rem_q;
	logic [DIM_W-1:0]    trial;
	logic [DIM_W-1:0]    trial_sub;

	// one quotient bit a cycle, restoring form
	always_comb begin
		trial     = {rem_q, dvd_q[COORD_W-1]};
		trial_sub = (trial >= dvs_q) ? trial - dvs_q : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(COORD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[COORD_W-2:0], 1'b0};
			rem_q <= trial_sub[COORD_W-1:0];
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

`default_nettype wire

### rtl/core/bpu_front.sv
// bpu_front: configuration registers, row/column bookkeeping and byte classification
// depends on bpu_pkg and bpu_intf; feeds jobs into the job queue
`default_nettype none

module bpu_front import bpu_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bpu_in_if.sink     item,
	bpu_cfg_if.sink    cfg,
	input  wire logic  q_full,
	output logic       push,
	output job_t       job,
	output rm_req_t    rm_req,
	input  rm_rsp_t    rm_rsp
);

	logic [BPP_W-1:0]   bpp_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;
	logic               rm_start_q;
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] rem_q;
	logic [BIR_W-1:0]   bir_q;
	logic [15:0]        pb_q;
	logic [1:0]         pc_q;

	logic [DIM_W-1:0]   w_eff;
	logic [DIM_W-1:0]   h_eff;
	logic               w_full;
	logic [17:0]        row_bits;
	logic [BIR_W-1:0]   stride;
	logic [BIR_W:0]     padded;
	logic [BIR_W:0]     bir_inc;
	logic               row_end;
	logic               in_data;
	logic               supported;
	logic [DIM_W-1:0]   row_inc;
	logic [COORD_W-1:0] row_wrap;
	logic [DIM_W-1:0]   y_full;
	logic [DIM_W-1:0]   room;

	logic               accept;
	logic               is_data;
	logic [CNT_W-1:0]   k;
	logic               try_emit;
	logic [CNT_W-1:0]   n;
	logic [15:0]        pb_d;
	logic [1:0]         pc_d;
	logic [15:0]        word16;
	job_t               pix_job;

	assign accept  = item.valid && item.ready;
	assign is_data = accept && (item.action == ACT_DATA);

	// hold off until the new row remainder has landed in rem_q
	assign item.ready = !q_full && !rm_rsp.busy && !rm_rsp.done && !rm_start_q;
	assign cfg.ready  = 1'b1;

	// clamped geometry and row stride
	always_comb begin
		w_eff = width_q;
		if (width_q == '0)
			w_eff = DIM_W'(1);
		else if (width_q > DIM_W'(W_LIMIT))
			w_eff = DIM_W'(W_LIMIT);
		h_eff = height_q;
		if (height_q == '0)
			h_eff = DIM_W'(1);
		else if (height_q > DIM_W'(DIM_LIMIT))
			h_eff = DIM_W'(DIM_LIMIT);
		w_full = (w_eff == DIM_W'(DIM_LIMIT));

		unique case (bpp_q)
			BPP_1:   row_bits = 18'(w_eff);
			BPP_4:   row_bits = 18'(w_eff) << 2;
			BPP_8:   row_bits = 18'(w_eff) << 3;
			BPP_16:  row_bits = 18'(w_eff) << 4;
			BPP_24:  row_bits = (18'(w_eff) << 4) + (18'(w_eff) << 3);
			BPP_32:  row_bits = 18'(w_eff) << 5;
			default: row_bits = '0;
		endcase
		supported = (bpp_q == BPP_1) || (bpp_q == BPP_4) || (bpp_q == BPP_8) ||
			(bpp_q == BPP_16) || (bpp_q == BPP_24) || (bpp_q == BPP_32);

		stride  = BIR_W'((row_bits + 18'd7) >> 3);
		padded  = ((BIR_W+1)'(stride) + (BIR_W+1)'(3)) & ~(BIR_W+1)'(3);
		bir_inc = (BIR_W+1)'(bir_q) + 1'b1;
		row_end = (bir_inc >= padded);
		in_data = (bir_q < stride);

		row_inc  = DIM_W'(row_q) + 1'b1;
		row_wrap = (row_inc >= h_eff) ? '0 : row_inc[COORD_W-1:0];
		y_full   = h_eff - DIM_W'(1) - DIM_W'(rem_q);
	end

	// per-depth decode of the byte
	always_comb begin
		pix_job       = '0;
		pix_job.col   = col_q;
		pix_job.y     = y_full[COORD_W-1:0];
		pix_job.data  = item.data_byte;
		k             = '0;
		try_emit      = 1'b0;
		pb_d          = pb_q;
		pc_d          = pc_q;
		word16        = {item.data_byte, pb_q[7:0]};

		unique case (bpp_q)
			BPP_1: begin
				pix_job.kind  = JOB_PAL;
				pix_job.depth = PD_1;
				k             = CNT_W'(8);
				try_emit      = in_data;
			end
			BPP_4: begin
				pix_job.kind  = JOB_PAL;
				pix_job.depth = PD_4;
				k             = CNT_W'(2);
				try_emit      = in_data;
			end
			BPP_8: begin
				pix_job.kind  = JOB_PAL;
				pix_job.depth = PD_8;
				k             = CNT_W'(1);
				try_emit      = in_data;
			end
			BPP_16: begin
				pix_job.kind  = JOB_RGB;
				pix_job.red   = {3'b000, word16[14:10]};
				pix_job.green = {3'b000, word16[9:5]};
				pix_job.blue  = {3'b000, word16[4:0]};
				k             = CNT_W'(1);
				if (in_data) begin
					if (pc_q == 2'd0) begin
						pb_d = {8'h00, item.data_byte};
						pc_d = 2'd1;
					end else begin
						try_emit = 1'b1;
						pb_d     = '0;
						pc_d     = 2'd0;
					end
				end
			end
			BPP_24, BPP_32: begin
				pix_job.kind  = JOB_RGB;
				pix_job.red   = item.data_byte;
				pix_job.green = pb_q[15:8];
				pix_job.blue  = pb_q[7:0];
				k             = CNT_W'(1);
				if (in_data) begin
					if (pc_q == 2'd0) begin
						pb_d = pb_q | {8'h00, item.data_byte};
						pc_d = 2'd1;
					end else if (pc_q == 2'd1) begin
						pb_d = pb_q | {item.data_byte, 8'h00};
						pc_d = 2'd2;
					end else if (pc_q == 2'd2) begin
						try_emit = 1'b1;
						pb_d     = '0;
						pc_d     = (bpp_q == BPP_32) ? 2'd3 : 2'd0;
					end else begin
						pc_d = 2'd0;
					end
				end
			end
			default: begin
				pix_job.kind = JOB_ERR;
			end
		endcase

		// pixels of this byte that still fall inside the row
		room = w_eff - DIM_W'(col_q);
		if (!try_emit)
			n = '0;
		else if (w_full)
			n = k;
		else if (DIM_W'(col_q) >= w_eff)
			n = '0;
		else if (room >= DIM_W'(k))
			n = k;
		else
			n = room[CNT_W-1:0];
		pix_job.count = n;
	end

	// job towards the back
	always_comb begin
		job  = pix_job;
		push = 1'b0;
		if (accept && (item.action == ACT_PALETTE)) begin
			job       = '0;
			job.kind  = JOB_PWR;
			job.data  = item.palette_index;
			job.red   = item.palette_red;
			job.green = item.palette_green;
			job.blue  = item.palette_blue;
			push      = 1'b1;
		end else if (is_data && !supported) begin
			job       = '0;
			job.kind  = JOB_ERR;
			job.count = CNT_W'(1);
			push      = 1'b1;
		end else if (is_data) begin
			push = (n != '0);
		end
	end

	assign rm_req.start    = rm_start_q;
	assign rm_req.divisor  = h_eff;
	assign rm_req.dividend = row_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q      <= BPP_RESET;
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
			rm_start_q <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			rem_q      <= '0;
			bir_q      <= '0;
			pb_q       <= '0;
			pc_q       <= '0;
		end else begin
			rm_start_q <= 1'b0;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.index)
					REG_BPP:    bpp_q <= cfg.data[BPP_W-1:0];
					REG_WIDTH:  width_q <= cfg.data;
					REG_HEIGHT: begin
						height_q   <= cfg.data;
						rm_start_q <= 1'b1;
					end
					default: ;
				endcase
			end

			if (rm_rsp.done)
				rem_q <= rm_rsp.rem;

			if (accept && (item.action == ACT_START)) begin
				col_q <= '0;
				row_q <= '0;
				rem_q <= '0;
				bir_q <= '0;
				pb_q  <= '0;
				pc_q  <= '0;
			end else if (is_data && supported) begin
				if (row_end) begin
					col_q <= '0;
					row_q <= row_wrap;
					rem_q <= row_wrap;
					bir_q <= '0;
					pb_q  <= '0;
					pc_q  <= '0;
				end else begin
					col_q <= col_q + COORD_W'(n);
					bir_q <= bir_inc[BIR_W-1:0];
					pb_q  <= pb_d;
					pc_q  <= pc_d;
				end
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/bpu_jobq.sv
// bpu_jobq: small job queue between the front and back parts
// depends on bpu_pkg (job_t)
`default_nettype none

module bpu_jobq import bpu_pkg::*; #(
	parameter int DEPTH = JOBQ_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  job_t      din,
	input  wire logic pop,
	output job_t      dout,
	output logic      valid,
	output logic      full
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_QW = $clog2(DEPTH + 1);

	job_t               slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [CNT_QW-1:0]  cnt_q;

	assign dout  = slot_q[rd_q];
	assign valid = (cnt_q != '0);
	assign full  = (cnt_q == CNT_QW'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= din;
	end

endmodule

`default_nettype wire

### rtl/core/bpu_back.sv
// bpu_back: palette memory and pixel expansion of queued jobs onto the output channel
// depends on bpu_pkg and bpu_intf
`default_nettype none

module bpu_back import bpu_pkg::*; #(
	parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  job_t      job,
	input  wire logic job_valid,
	output logic      pop,
	bpu_out_if.source pixel
);

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	logic [3*BYTE_W-1:0] pal_mem [PALETTE_DEPTH];

	logic [PIX_W-1:0]    k_q;
	logic                valid_s2;
	logic [COORD_W-1:0]  x_s2;
	logic [COORD_W-1:0]  y_s2;
	logic [3*BYTE_W-1:0] rgb_s2;
	logic                pal_s2;
	logic                oor_s2;
	logic                err_s2;
	logic                last_s2;
	logic [3*BYTE_W-1:0] rd_q;

	logic                is_pwr;
	logic                adv;
	logic                issue;
	logic                last_pix;
	logic [BYTE_W-1:0]   idx;
	logic                idx_oor;
	logic [3*BYTE_W-1:0] colour;

	assign is_pwr   = job_valid && (job.kind == JOB_PWR);
	assign adv      = !valid_s2 || pixel.ready;
	assign issue    = job_valid && (job.kind != JOB_PWR) && adv;
	assign last_pix = ({1'b0, k_q} == (job.count - 1'b1));
	assign pop      = is_pwr || (issue && last_pix);

	// palette index of the current pixel
	always_comb begin
		unique case (job.depth)
			PD_1:    idx = {7'd0, job.data[3'd7 - k_q]};
			PD_4:    idx = (k_q == '0) ? {4'd0, job.data[7:4]} : {4'd0, job.data[3:0]};
			PD_8:    idx = job.data;
			default: idx = job.data;
		endcase
		idx_oor = ({1'b0, job.data} >= 9'(PALETTE_DEPTH)) && (job.kind == JOB_PWR) ||
			({1'b0, idx} >= 9'(PALETTE_DEPTH)) && (job.kind != JOB_PWR);
	end

	always_ff @(posedge clk) begin
		if (is_pwr && !idx_oor)
			pal_mem[job.data[AW-1:0]] <= {job.red, job.green, job.blue};
		if (issue)
			rd_q <= pal_mem[idx[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q      <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv)
				valid_s2 <= issue;
			if (issue)
				k_q <= last_pix ? '0 : k_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			x_s2    <= job.col + COORD_W'(k_q);
			y_s2    <= job.y;
			rgb_s2  <= {job.red, job.green, job.blue};
			pal_s2  <= (job.kind == JOB_PAL);
			oor_s2  <= idx_oor;
			err_s2  <= (job.kind == JOB_ERR);
			last_s2 <= last_pix;
		end
	end

	always_comb begin
		if (!pal_s2)
			colour = rgb_s2;
		else if (oor_s2)
			colour = '0;
		else
			colour = rd_q;
	end

	assign pixel.valid   = valid_s2;
	assign pixel.pixel_x = x_s2;
	assign pixel.pixel_y = y_s2;
	assign pixel.red     = colour[3*BYTE_W-1:2*BYTE_W];
	assign pixel.green   = colour[2*BYTE_W-1:BYTE_W];
	assign pixel.blue    = colour[BYTE_W-1:0];
	assign pixel.status  = err_s2;
	assign pixel.last    = last_s2;

endmodule

`default_nettype wire
